@@ sv/dld_pkg.sv @@
// Package for the decimal long divider: digit constants, controller states and control structs.
`default_nettype none

package dld_pkg;

   localparam int DIGIT_W     = 4;
   localparam int POS_W       = 5;
   localparam int RADIX       = 10;
   localparam int MAX_DIGIT   = 9;
   localparam int QUOT_LIMIT  = 15;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUB,
      ST_SUB_DRAIN,
      ST_CHECK,
      ST_ADD,
      ST_ADD_DRAIN,
      ST_SHIFT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      OP_SUB,
      OP_ADD,
      OP_OUT
   } op_type;

   typedef struct packed {
      logic   load;
      logic   run_start;
      logic   zero_rsp;
      logic   pass_clear;
      logic   issue;
      op_type op;
      logic   q_inc;
      logic   shift_done;
   } cmd_type;

   typedef struct packed {
      logic last_issue;
      logic fail;
      logic q_near_cap;
      logic sh_zero;
      logic divisor_nonzero;
   } status_type;

endpackage

`default_nettype wire

@@ sv/dld_ctrl.sv @@
// Controller state machine for the decimal long divider.
`default_nettype none

module dld_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   input  wire                   last_position,
   input  wire dld_pkg::status_type status,
   output dld_pkg::cmd_type      cmd,
   output logic                  busy
);
   import dld_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && last_position && status.divisor_nonzero) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            if (status.last_issue) begin
               state_in = ST_SUB_DRAIN;
            end
         end
         ST_SUB_DRAIN: state_in = ST_CHECK;
         ST_CHECK: begin
            if (status.fail) begin
               state_in = ST_ADD;
            end else if (status.q_near_cap) begin
               state_in = ST_SHIFT;
            end else begin
               state_in = ST_SUB;
            end
         end
         ST_ADD: begin
            if (status.last_issue) begin
               state_in = ST_ADD_DRAIN;
            end
         end
         ST_ADD_DRAIN: state_in = ST_SHIFT;
         ST_SHIFT: begin
            if (status.sh_zero) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_SUB;
            end
         end
         ST_OUT: begin
            if (status.last_issue) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (last_position) begin
                  cmd.run_start  = 1'b1;
                  cmd.pass_clear = 1'b1;
                  cmd.zero_rsp   = !status.divisor_nonzero;
               end
            end
         end
         ST_SUB: begin
            cmd.issue = 1'b1;
            cmd.op    = OP_SUB;
         end
         ST_SUB_DRAIN: cmd.op = OP_SUB;
         ST_CHECK: begin
            cmd.pass_clear = 1'b1;
            cmd.q_inc      = !status.fail;
         end
         ST_ADD: begin
            cmd.issue = 1'b1;
            cmd.op    = OP_ADD;
         end
         ST_ADD_DRAIN: cmd.op = OP_ADD;
         ST_SHIFT: begin
            cmd.shift_done = 1'b1;
            cmd.pass_clear = 1'b1;
         end
         ST_OUT: begin
            cmd.issue = 1'b1;
            cmd.op    = OP_OUT;
         end
         default: begin
            cmd  = '0;
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ sv/dld_datapath.sv @@
// Datapath for the decimal long divider: digit stores, digit-serial subtract and restore, result stage.
`default_nettype none

module dld_datapath #(
   parameter int DIGIT_COUNT = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire dld_pkg::cmd_type        cmd,
   input  wire  [dld_pkg::DIGIT_W-1:0]  req_dividend_digit,
   input  wire  [dld_pkg::DIGIT_W-1:0]  req_divisor_digit,
   output dld_pkg::status_type          status,
   output logic                         rsp_strobe,
   output logic [dld_pkg::DIGIT_W-1:0]  rsp_quotient_digit,
   output logic [dld_pkg::DIGIT_W-1:0]  rsp_remainder_digit,
   output logic [dld_pkg::POS_W-1:0]    rsp_digit_position,
   output logic                         rsp_divide_by_zero,
   output logic                         rsp_final_digit
);
   import dld_pkg::*;

   localparam int IDX_W     = $clog2(DIGIT_COUNT);
   localparam int LP_W      = $clog2(DIGIT_COUNT + 1);
   localparam int POS_EXT_W = IDX_W + POS_W;

   logic [DIGIT_W-1:0] r_mem [DIGIT_COUNT];
   logic [DIGIT_W-1:0] d_mem [DIGIT_COUNT];
   logic [DIGIT_W-1:0] q_mem [DIGIT_COUNT];

   logic [LP_W-1:0]    lp_ff,     lp_in;
   logic [IDX_W-1:0]   cnt_m1_ff, cnt_m1_in;
   logic [IDX_W-1:0]   sh_ff,     sh_in;
   logic [IDX_W-1:0]   j_ff,      j_in;
   logic [DIGIT_W-1:0] q_ff,      q_in;
   logic               carry_ff,  carry_in;
   logic               ovf_ff,    ovf_in;
   logic               nz_low_ff, nz_low_in;
   logic               top_nz_ff, top_nz_in;
   logic               dz_ff;

   logic               s1_v_ff;
   op_type             s1_op_ff;
   logic               s1_inr_ff;
   logic               s1_last_ff;
   logic [IDX_W-1:0]   s1_addr_ff;
   logic [DIGIT_W-1:0] r_rd_ff, d_rd_ff, q_rd_ff;

   logic [DIGIT_W-1:0] dvd_clamp, dvs_clamp;
   logic [IDX_W-1:0]   load_idx;
   logic               is_top;
   logic [LP_W-1:0]    cnt_in;
   logic [IDX_W:0]     sum;
   logic               in_range;
   logic [IDX_W-1:0]   rd_addr;
   logic               last_issue;

   logic [DIGIT_W:0]   sub_val;
   logic [DIGIT_W:0]   add_val;
   logic [DIGIT_W-1:0] s1_result;
   logic               s1_carry;
   logic               s1_wr;

   logic               r_we;
   logic [IDX_W-1:0]   r_wa;
   logic [DIGIT_W-1:0] r_wd;
   logic [POS_EXT_W-1:0] pos_ext;

   assign dvd_clamp = (req_dividend_digit > DIGIT_W'(MAX_DIGIT)) ?
                      DIGIT_W'(MAX_DIGIT) : req_dividend_digit;
   assign dvs_clamp = (req_divisor_digit > DIGIT_W'(MAX_DIGIT)) ?
                      DIGIT_W'(MAX_DIGIT) : req_divisor_digit;

   assign is_top   = (lp_ff >= LP_W'(DIGIT_COUNT - 1));
   assign load_idx = is_top ? IDX_W'(DIGIT_COUNT - 1) : lp_ff[IDX_W-1:0];
   assign cnt_in   = (lp_ff == LP_W'(DIGIT_COUNT)) ? lp_ff : lp_ff + LP_W'(1);

   assign sum        = {1'b0, j_ff} + {1'b0, sh_ff};
   assign in_range   = (sum <= {1'b0, cnt_m1_ff});
   assign last_issue = (j_ff == cnt_m1_ff);

   always_comb begin
      if (cmd.op == OP_OUT) begin
         rd_addr = j_ff;
      end else if (in_range) begin
         rd_addr = sum[IDX_W-1:0];
      end else begin
         rd_addr = '0;
      end
   end

   always_comb begin
      status.last_issue      = last_issue;
      status.fail            = carry_ff || ovf_ff;
      status.q_near_cap      = (q_ff == DIGIT_W'(QUOT_LIMIT - 1));
      status.sh_zero         = (sh_ff == '0);
      status.divisor_nonzero = nz_low_ff || (dvs_clamp != '0) ||
                               (!is_top && top_nz_ff);
   end

   // digit-serial stage on the registered read data
   always_comb begin
      sub_val   = {1'b0, d_rd_ff} + {{DIGIT_W{1'b0}}, carry_ff};
      add_val   = {1'b0, r_rd_ff} + {1'b0, d_rd_ff} + {{DIGIT_W{1'b0}}, carry_ff};
      s1_result = '0;
      s1_carry  = carry_ff;
      case (s1_op_ff)
         OP_SUB: begin
            if ({1'b0, r_rd_ff} < sub_val) begin
               s1_result = DIGIT_W'({1'b0, r_rd_ff} + (DIGIT_W + 1)'(RADIX) - sub_val);
               s1_carry  = 1'b1;
            end else begin
               s1_result = DIGIT_W'({1'b0, r_rd_ff} - sub_val);
               s1_carry  = 1'b0;
            end
         end
         OP_ADD: begin
            if (add_val >= (DIGIT_W + 1)'(RADIX)) begin
               s1_result = DIGIT_W'(add_val - (DIGIT_W + 1)'(RADIX));
               s1_carry  = 1'b1;
            end else begin
               s1_result = DIGIT_W'(add_val);
               s1_carry  = 1'b0;
            end
         end
         default: begin
            s1_result = '0;
            s1_carry  = carry_ff;
         end
      endcase
      s1_wr = s1_v_ff && s1_inr_ff && (s1_op_ff != OP_OUT);
   end

   always_comb begin
      lp_in     = lp_ff;
      cnt_m1_in = cnt_m1_ff;
      sh_in     = sh_ff;
      j_in      = j_ff;
      q_in      = q_ff;
      carry_in  = carry_ff;
      ovf_in    = ovf_ff;
      nz_low_in = nz_low_ff;
      top_nz_in = top_nz_ff;

      if (s1_wr) begin
         carry_in = s1_carry;
      end
      if (s1_v_ff && !s1_inr_ff && (s1_op_ff == OP_SUB) && (d_rd_ff != '0)) begin
         ovf_in = 1'b1;
      end

      if (cmd.issue && !last_issue) begin
         j_in = j_ff + IDX_W'(1);
      end
      if (cmd.pass_clear) begin
         j_in     = '0;
         carry_in = 1'b0;
         ovf_in   = 1'b0;
      end

      if (cmd.q_inc) begin
         q_in = q_ff + DIGIT_W'(1);
      end
      if (cmd.shift_done) begin
         q_in  = '0;
         sh_in = sh_ff - IDX_W'(1);
      end

      if (cmd.load) begin
         if (cmd.run_start) begin
            lp_in     = '0;
            cnt_m1_in = IDX_W'(cnt_in - LP_W'(1));
            sh_in     = IDX_W'(cnt_in - LP_W'(1));
            q_in      = '0;
            nz_low_in = 1'b0;
            top_nz_in = 1'b0;
         end else begin
            lp_in = cnt_in;
            if (is_top) begin
               top_nz_in = (dvs_clamp != '0);
            end else begin
               nz_low_in = nz_low_ff || (dvs_clamp != '0);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lp_ff     <= '0;
         nz_low_ff <= 1'b0;
         top_nz_ff <= 1'b0;
         dz_ff     <= 1'b0;
         s1_v_ff   <= 1'b0;
         carry_ff  <= 1'b0;
         ovf_ff    <= 1'b0;
         j_ff      <= '0;
         q_ff      <= '0;
         sh_ff     <= '0;
         cnt_m1_ff <= '0;
      end else begin
         lp_ff     <= lp_in;
         nz_low_ff <= nz_low_in;
         top_nz_ff <= top_nz_in;
         dz_ff     <= cmd.zero_rsp;
         s1_v_ff   <= cmd.issue;
         carry_ff  <= carry_in;
         ovf_ff    <= ovf_in;
         j_ff      <= j_in;
         q_ff      <= q_in;
         sh_ff     <= sh_in;
         cnt_m1_ff <= cnt_m1_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= cmd.op;
      s1_inr_ff  <= in_range;
      s1_last_ff <= last_issue;
      s1_addr_ff <= rd_addr;
   end

   assign r_we = cmd.load || s1_wr;
   assign r_wa = cmd.load ? load_idx : s1_addr_ff;
   assign r_wd = cmd.load ? dvd_clamp : s1_result;

   always_ff @(posedge clock) begin
      if (r_we) begin
         r_mem[r_wa] <= r_wd;
      end
      r_rd_ff <= r_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         d_mem[load_idx] <= dvs_clamp;
      end
      d_rd_ff <= d_mem[j_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.shift_done) begin
         q_mem[sh_ff] <= q_ff;
      end
      q_rd_ff <= q_mem[j_ff];
   end

   assign pos_ext = POS_EXT_W'(s1_addr_ff);

   assign rsp_strobe          = (s1_v_ff && (s1_op_ff == OP_OUT)) || dz_ff;
   assign rsp_quotient_digit  = dz_ff ? '0 : q_rd_ff;
   assign rsp_remainder_digit = dz_ff ? '0 : r_rd_ff;
   assign rsp_digit_position  = dz_ff ? '0 : pos_ext[POS_W-1:0];
   assign rsp_divide_by_zero  = dz_ff;
   assign rsp_final_digit     = dz_ff || s1_last_ff;

endmodule

`default_nettype wire

@@ sv/decimal_long_divider.sv @@
// Top level of the decimal long divider: controller and datapath.
//
//   channel  ports                               handshake
//   request  req_dividend_digit, req_divisor_digit,  beat when start && !busy
//            req_last_position
//   response rsp_quotient_digit, rsp_remainder_digit, beat on each rsp_strobe cycle
//            rsp_digit_position, rsp_divide_by_zero,
//            rsp_final_digit
//
// The beat with req_last_position starts the run: with n positions, each shift runs
// subtract passes until a trial fails or the quotient digit reaches its cap, a restore
// pass when the last trial fails, and a step to store the digit; then n result beats
// on consecutive cycles. Each pass walks the digit stores one position a cycle,
// reading one position while writing back the one before.
// A zero divisor gives one beat the next cycle.
// Reset is synchronous; digit stores are not cleared. The receiver cannot stall.
`default_nettype none

module decimal_long_divider #(
   parameter int DIGIT_COUNT = 32
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [dld_pkg::DIGIT_W-1:0]  req_dividend_digit,
   input  wire  [dld_pkg::DIGIT_W-1:0]  req_divisor_digit,
   input  wire                          req_last_position,
   output logic                         rsp_strobe,
   output logic [dld_pkg::DIGIT_W-1:0]  rsp_quotient_digit,
   output logic [dld_pkg::DIGIT_W-1:0]  rsp_remainder_digit,
   output logic [dld_pkg::POS_W-1:0]    rsp_digit_position,
   output logic                         rsp_divide_by_zero,
   output logic                         rsp_final_digit
);
   import dld_pkg::*;

   cmd_type    cmd;
   status_type status;

   dld_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .last_position (req_last_position),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   dld_datapath #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_dividend_digit  (req_dividend_digit),
      .req_divisor_digit   (req_divisor_digit),
      .status              (status),
      .rsp_strobe          (rsp_strobe),
      .rsp_quotient_digit  (rsp_quotient_digit),
      .rsp_remainder_digit (rsp_remainder_digit),
      .rsp_digit_position  (rsp_digit_position),
      .rsp_divide_by_zero  (rsp_divide_by_zero),
      .rsp_final_digit     (rsp_final_digit)
   );

endmodule

`default_nettype wire
